[hdl/lkv_pkg.sv]
// Shared constants, command codes and controller/datapath interface types for the LRU cache.
`default_nettype none
package lkv_pkg;

	localparam int ENTRIES_DEF    = 16;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;

	localparam int              CAP_BITS  = 5;
	localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

	localparam int              CMD_BITS = 2;
	localparam logic [CMD_BITS-1:0] CMD_GET  = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_PUT  = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_DEL  = 2'd2;

	// controller -> datapath commands
	typedef struct packed {
		logic load;
		logic scan;
		logic plan;
		logic update;
		logic commit;
		logic rd_en;
	} lkv_ctl_t;

	// datapath -> controller status
	typedef struct packed {
		logic need_upd;
	} lkv_sts_t;

endpackage
`default_nettype wire

[hdl/lkv_ctrl.sv]
// Controller: sequences the scan, plan, rank update and commit phases of one item.
`default_nettype none
module lkv_ctrl import lkv_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire lkv_sts_t                     sts,
	output lkv_ctl_t                          ctl,
	output logic [$clog2(ENTRIES)-1:0]        addr
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PLAN,
		ST_UPDATE,
		ST_COMMIT
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               last;

	assign last = (cnt_q == CNT_W'(ENTRIES));
	assign addr = cnt_q[IDX_W-1:0];
	assign busy = busy_q;

	always_comb begin
		ctl        = '0;
		ctl.load   = (state_q == ST_IDLE) && start && !busy_q;
		ctl.scan   = (state_q == ST_SCAN);
		ctl.plan   = (state_q == ST_PLAN);
		ctl.update = (state_q == ST_UPDATE);
		ctl.commit = (state_q == ST_COMMIT);
		ctl.rd_en  = ((state_q == ST_SCAN) || (state_q == ST_UPDATE)) && !last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start && !busy_q) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
						busy_q  <= 1'b1;
					end
				end
				ST_SCAN: begin
					// staying in scan while last is set lets the last read be evaluated
					if (last) begin
						state_q <= ST_PLAN;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_PLAN: begin
					cnt_q   <= '0;
					state_q <= sts.need_upd ? ST_UPDATE : ST_COMMIT;
				end
				ST_UPDATE: begin
					if (last) begin
						state_q <= ST_COMMIT;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_COMMIT: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[hdl/lkv_datapath.sv]
// Datapath: key/value/rank memories, valid bits, scan search, rank update and result registers.
`default_nettype none
module lkv_datapath import lkv_pkg::*; #(
	parameter int ENTRIES    = ENTRIES_DEF,
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire lkv_ctl_t                     ctl,
	input  wire logic [$clog2(ENTRIES)-1:0]   addr,
	output lkv_sts_t                          sts,
	input  wire logic                         cfg_we,
	input  wire logic [CAP_BITS-1:0]          cfg_data,
	input  wire logic [CMD_BITS-1:0]          command,
	input  wire logic [KEY_BITS-1:0]          key,
	input  wire logic [VALUE_BITS-1:0]        value,
	output logic                              done,
	output logic                              found,
	output logic [VALUE_BITS-1:0]             read_value,
	output logic                              evicted
);

	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int RANK_W = IDX_W;
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int CMP_W  = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

	// memories
	logic [KEY_BITS-1:0]   key_mem  [ENTRIES];
	logic [VALUE_BITS-1:0] val_mem  [ENTRIES];
	logic [RANK_W-1:0]     rank_mem [ENTRIES];

	logic [ENTRIES-1:0]    valid_q;
	logic [CNT_W-1:0]      used_q;
	logic [CAP_BITS-1:0]   cap_q;

	// latched item
	logic [CMD_BITS-1:0]   cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;

	// read pipeline
	logic [KEY_BITS-1:0]   key_rd_s1;
	logic [VALUE_BITS-1:0] val_rd_s1;
	logic [RANK_W-1:0]     rank_rd_s1;
	logic [IDX_W-1:0]      addr_s1;
	logic                  eval_s1;
	logic                  wr_s1;

	// scan results
	logic                  hit_q;
	logic [IDX_W-1:0]      hit_idx_q;
	logic [RANK_W-1:0]     hit_rank_q;
	logic [VALUE_BITS-1:0] hit_val_q;
	logic                  free_fnd_q;
	logic [IDX_W-1:0]      free_idx_q;
	logic                  lru_fnd_q;
	logic [IDX_W-1:0]      lru_idx_q;
	logic [RANK_W-1:0]     lru_rank_q;

	// plan results
	logic [IDX_W-1:0]      tgt_q;
	logic                  alloc_q;
	logic                  evict_q;

	// result registers
	logic                  done_q;
	logic                  found_q;
	logic [VALUE_BITS-1:0] rdval_q;
	logic                  evicted_q;

	logic                  is_get;
	logic                  is_put;
	logic                  is_del;
	logic [CMP_W-1:0]      cap_ext;
	logic [CMP_W-1:0]      cap_eff;
	logic                  room;
	logic                  cur_valid;
	logic [RANK_W-1:0]     rank_new;
	logic [IDX_W-1:0]      wr_idx;

	assign is_get = (cmd_q == CMD_GET);
	assign is_put = (cmd_q == CMD_PUT);
	assign is_del = (cmd_q == CMD_DEL);

	assign sts.need_upd = ((is_get || is_del) && hit_q) || is_put;

	always_comb begin
		cap_ext = CMP_W'(cap_q);
		cap_eff = cap_ext;
		if (cap_q == '0) begin
			cap_eff = CMP_W'(1);
		end else if (cap_ext > CMP_W'(ENTRIES)) begin
			cap_eff = CMP_W'(ENTRIES);
		end
	end

	assign room      = (CMP_W'(used_q) < cap_eff) && free_fnd_q;
	assign cur_valid = valid_q[addr_s1];

	// new rank of the entry read back during the update pass
	always_comb begin
		rank_new = rank_rd_s1;
		if (is_put && !hit_q) begin
			if (addr_s1 == tgt_q) begin
				rank_new = '0;
			end else if (cur_valid) begin
				rank_new = rank_rd_s1 + RANK_W'(1);
			end
		end else if (is_del) begin
			if (cur_valid && (rank_rd_s1 > hit_rank_q)) begin
				rank_new = rank_rd_s1 - RANK_W'(1);
			end
		end else begin
			// promote on a hit
			if (addr_s1 == hit_idx_q) begin
				rank_new = '0;
			end else if (cur_valid && (rank_rd_s1 < hit_rank_q)) begin
				rank_new = rank_rd_s1 + RANK_W'(1);
			end
		end
	end

	assign wr_idx = hit_q ? hit_idx_q : tgt_q;

	always_ff @(posedge clk) begin
		if (ctl.commit && is_put && !hit_q) begin
			key_mem[tgt_q] <= key_q;
		end
		if (ctl.rd_en) begin
			key_rd_s1 <= key_mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit && is_put) begin
			val_mem[wr_idx] <= val_q;
		end
		if (ctl.rd_en) begin
			val_rd_s1 <= val_mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_s1) begin
			rank_mem[addr_s1] <= rank_new;
		end
		if (ctl.rd_en) begin
			rank_rd_s1 <= rank_mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eval_s1 <= 1'b0;
			wr_s1   <= 1'b0;
		end else begin
			eval_s1 <= ctl.rd_en && ctl.scan;
			wr_s1   <= ctl.rd_en && ctl.update;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			addr_s1 <= addr;
		end
	end

	// item latch, scan search and plan
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q      <= command;
			key_q      <= key;
			val_q      <= value;
			hit_q      <= 1'b0;
			free_fnd_q <= 1'b0;
			lru_fnd_q  <= 1'b0;
		end
		if (eval_s1) begin
			if (cur_valid) begin
				if ((key_rd_s1 == key_q) && !hit_q) begin
					hit_q      <= 1'b1;
					hit_idx_q  <= addr_s1;
					hit_rank_q <= rank_rd_s1;
					hit_val_q  <= val_rd_s1;
				end
				if (!lru_fnd_q || (rank_rd_s1 > lru_rank_q)) begin
					lru_fnd_q  <= 1'b1;
					lru_idx_q  <= addr_s1;
					lru_rank_q <= rank_rd_s1;
				end
			end else if (!free_fnd_q) begin
				free_fnd_q <= 1'b1;
				free_idx_q <= addr_s1;
			end
		end
		if (ctl.plan) begin
			alloc_q <= room;
			evict_q <= !room && lru_fnd_q;
			if (room) begin
				tgt_q <= free_idx_q;
			end else if (lru_fnd_q) begin
				tgt_q <= lru_idx_q;
			end else begin
				tgt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			used_q  <= '0;
			cap_q   <= CAP_RESET;
			done_q  <= 1'b0;
		end else begin
			done_q <= ctl.commit;
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (ctl.commit) begin
				if (is_put && !hit_q) begin
					valid_q[tgt_q] <= 1'b1;
					if (alloc_q) begin
						used_q <= used_q + CNT_W'(1);
					end else if (!evict_q) begin
						used_q <= CNT_W'(1);
					end
				end else if (is_del && hit_q) begin
					valid_q[hit_idx_q] <= 1'b0;
					if (used_q != '0) begin
						used_q <= used_q - CNT_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			found_q   <= hit_q && (is_get || is_put || is_del);
			rdval_q   <= (is_get && hit_q) ? hit_val_q : '0;
			evicted_q <= is_put && !hit_q && evict_q;
		end
	end

	assign done       = done_q;
	assign found      = found_q;
	assign read_value = rdval_q;
	assign evicted    = evicted_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(ENTRIES))
		else $error("used count above entry count");

	a_done_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(ctl.commit))
		else $error("result strobe without commit");

	a_evict_is_miss: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(found_q && evicted_q))
		else $error("eviction reported on a hit");

	a_value_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (rdval_q != '0)) |-> found_q)
		else $error("read value without hit");

	a_no_load_midway: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.scan || ctl.update || ctl.plan) |-> !ctl.load)
		else $error("item loaded while one is in progress");

endmodule
`default_nettype wire

[hdl/lru_key_value_cache.sv]
// Top level of the fully associative LRU key-value cache.
//
// Usage: drive command/key/value with start; the item is taken at a clock edge where
// start is high and busy is low. Commands: 0 get, 1 put, 2 delete; code 3 is a no-op.
// The result (found, read_value, evicted) is shown for exactly one cycle with done
// high, in the same cycle that busy falls; the receiver cannot hold it off.
// Each item scans all ENTRIES slots through the key/value/rank memories (one slot per
// cycle, registered reads), plans the target slot, sweeps the rank memory once more to
// reorder recency when ranks change (get or delete hit, any put), then commits. A new
// item can be taken in the same cycle that done is shown, but not before: busy is high
// until then. capacity is written on cfg_data with cfg_valid (cfg_ready is always high);
// the user must write it only while idle, which the block itself does not enforce.
// 0 acts as 1 and values above ENTRIES act as ENTRIES.
// Reset (arst_n low) clears all valid marks and the use count and sets capacity to 16;
// no clearing pass is needed, so the block is ready right after reset.
`default_nettype none
module lru_key_value_cache import lkv_pkg::*; #(
	parameter int ENTRIES    = ENTRIES_DEF,
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [CMD_BITS-1:0]     command,
	input  wire logic [KEY_BITS-1:0]     key,
	input  wire logic [VALUE_BITS-1:0]   value,
	output logic                         done,
	output logic                         found,
	output logic [VALUE_BITS-1:0]        read_value,
	output logic                         evicted,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CAP_BITS-1:0]     cfg_data
);

	lkv_ctl_t                   ctl;
	lkv_sts_t                   sts;
	logic [$clog2(ENTRIES)-1:0] addr;

	assign cfg_ready = 1'b1;

	lkv_ctrl #(
		.ENTRIES (ENTRIES)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.ctl    (ctl),
		.addr   (addr)
	);

	lkv_datapath #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.addr       (addr),
		.sts        (sts),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.command    (command),
		.key        (key),
		.value      (value),
		.done       (done),
		.found      (found),
		.read_value (read_value),
		.evicted    (evicted)
	);

endmodule
`default_nettype wire
